FILE: hdl/trt_pkg.sv
// ----------------------------------------------------------------------------
// trt_pkg
// Shared constants, resistance table and controller/datapath interface types
// for the thermistor resistance to temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

  // Field widths
  localparam int unsigned RES_W  = 16;  // resistance code
  localparam int unsigned TEMP_W = 14;  // temperature, 0.01 degree

  // Defaults for the top-level parameters
  localparam int unsigned TABLE_ENTRIES_DEF = 121;
  localparam int unsigned SUB_STEPS_DEF     = 10;

  localparam int unsigned DEG_HUNDREDTHS = 100;

  // Descending resistance table, entry n is n whole degrees
  localparam int unsigned ROM_DEPTH = 121;
  localparam int unsigned ROM_IW    = $clog2(ROM_DEPTH);

  localparam logic [RES_W-1:0] RES_ROM [ROM_DEPTH] = '{
    16'd2208, 16'd2201, 16'd2194, 16'd2187, 16'd2180, 16'd2172, 16'd2163, 16'd2155,
    16'd2146, 16'd2137, 16'd2128, 16'd2118, 16'd2108, 16'd2097, 16'd2086, 16'd2075,
    16'd2064, 16'd2052, 16'd2040, 16'd2027, 16'd2014, 16'd2001, 16'd1987, 16'd1973,
    16'd1958, 16'd1944, 16'd1928, 16'd1913, 16'd1897, 16'd1880, 16'd1864, 16'd1847,
    16'd1829, 16'd1811, 16'd1793, 16'd1775, 16'd1756, 16'd1737, 16'd1717, 16'd1697,
    16'd1677, 16'd1657, 16'd1636, 16'd1615, 16'd1594, 16'd1572, 16'd1551, 16'd1529,
    16'd1507, 16'd1484, 16'd1462, 16'd1439, 16'd1416, 16'd1393, 16'd1370, 16'd1347,
    16'd1323, 16'd1300, 16'd1277, 16'd1253, 16'd1229, 16'd1206, 16'd1182, 16'd1159,
    16'd1135, 16'd1111, 16'd1088, 16'd1064, 16'd1041, 16'd1018, 16'd995,  16'd971,
    16'd949,  16'd926,  16'd903,  16'd881,  16'd858,  16'd836,  16'd814,  16'd792,
    16'd771,  16'd750,  16'd728,  16'd708,  16'd687,  16'd667,  16'd646,  16'd626,
    16'd607,  16'd587,  16'd568,  16'd549,  16'd531,  16'd513,  16'd494,  16'd477,
    16'd459,  16'd442,  16'd425,  16'd408,  16'd392,  16'd376,  16'd360,  16'd344,
    16'd329,  16'd314,  16'd299,  16'd285,  16'd271,  16'd257,  16'd243,  16'd230,
    16'd216,  16'd204,  16'd191,  16'd178,  16'd166,  16'd154,  16'd143,  16'd131,
    16'd120
  };

  // Table read; entries past the end read as zero
  function automatic logic [RES_W-1:0] rom_entry(input logic [7:0] idx);
    logic [RES_W-1:0] val;
    val = '0;
    if (idx < 8'(ROM_DEPTH)) begin
      val = RES_ROM[idx[ROM_IW-1:0]];
    end
    return val;
  endfunction

  // Controller -> datapath
  typedef struct packed {
    logic start;       // capture input word, point at entry 1
    logic scan_next;   // advance table index
    logic div_load;    // load interval width
    logic div_step;    // interval width -> sub-step width
    logic int_step;    // one sub-step check
    logic set_oor;     // pending result: out of range
    logic set_exact;   // pending result: exact entry
    logic set_interp;  // pending result: interpolated
    logic push;        // pending result into output register
  } trt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_range;
    logic match;
    logic below;
    logic int_hit;
    logic int_last;
    logic out_free;
  } trt_sts_t;

endpackage

`default_nettype wire

FILE: hdl/trt_ctrl.sv
// ----------------------------------------------------------------------------
// trt_ctrl
// Sequencer: range check, table scan, step divide, sub-step search, output.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output      logic              s_axis_tready_o,
  input  wire trt_pkg::trt_sts_t sts_i,
  output      trt_pkg::trt_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_INTERP = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.in_range) begin
          cmd_o.set_oor = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.match) begin
          cmd_o.set_exact = 1'b1;
          state_d         = ST_FINISH;
        end else if (sts_i.below) begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.int_step = 1'b1;
        if (sts_i.int_hit || sts_i.int_last) begin
          cmd_o.set_interp = 1'b1;
          state_d          = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/trt_dp.sv
// ----------------------------------------------------------------------------
// trt_dp
// Datapath: table index, reciprocal multiply for the sub-step width,
// sub-step accumulator, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_dp #(
  parameter int unsigned TABLE_ENTRIES = trt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SUB_STEPS     = trt_pkg::SUB_STEPS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [trt_pkg::RES_W-1:0]  resistance_i,
  input  wire trt_pkg::trt_cmd_t          cmd_i,
  output      trt_pkg::trt_sts_t          sts_o,
  input  wire logic                       m_ready_i,
  output      logic                       m_valid_o,
  output      logic [trt_pkg::TEMP_W-1:0] temperature_o,
  output      logic                       out_of_range_o
);

  localparam int unsigned RES_W  = trt_pkg::RES_W;
  localparam int unsigned TEMP_W = trt_pkg::TEMP_W;
  localparam int unsigned IW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned KW     = $clog2(SUB_STEPS + 1);
  localparam int unsigned SubInc = trt_pkg::DEG_HUNDREDTHS / SUB_STEPS;

  // floor(x / SUB_STEPS) = (x * RecipMul) >> RecipShift for any RES_W-bit x
  localparam int unsigned     RecipShift = RES_W + $clog2(SUB_STEPS);
  localparam longint unsigned RecipMul   =
    ((64'd1 << RecipShift) + 64'(SUB_STEPS) - 64'd1) / 64'(SUB_STEPS);
  localparam int unsigned     PW         = RecipShift + RES_W;

  localparam logic [RES_W-1:0] FirstEntry = trt_pkg::rom_entry(8'd0);
  localparam logic [RES_W-1:0] LastEntry  = trt_pkg::rom_entry(8'(TABLE_ENTRIES - 1));

  logic [RES_W-1:0]  r_q;
  logic [IW-1:0]     idx_q;
  logic [RES_W-1:0]  quot_q;    // interval width in, step out
  logic [RES_W-1:0]  acc_q;     // upper - k*step
  logic [KW-1:0]     k_q;
  logic [TEMP_W-1:0] res_temp_q;
  logic              res_oor_q;
  logic              m_valid_q;
  logic [TEMP_W-1:0] m_temp_q;
  logic              m_oor_q;

  logic [IW-1:0]     idx_m1;
  logic [RES_W-1:0]  entry, upper;
  logic [PW-1:0]     prod;
  logic [RES_W-1:0]  acc_nxt;
  logic [KW-1:0]     k_nxt;
  logic              hit;
  logic [TEMP_W-1:0] base_temp, exact_temp, frac_temp;

  assign idx_m1 = idx_q - IW'(1);
  assign entry  = trt_pkg::rom_entry(8'(idx_q));
  assign upper  = trt_pkg::rom_entry(8'(idx_m1));

  // divide by SUB_STEPS through the constant reciprocal
  assign prod = PW'(quot_q) * PW'(RecipMul);

  assign acc_nxt = acc_q - quot_q;
  assign k_nxt   = k_q + KW'(1);
  assign hit     = (acc_nxt < r_q);

  assign base_temp  = TEMP_W'(32'(idx_m1) * trt_pkg::DEG_HUNDREDTHS);
  assign exact_temp = TEMP_W'(32'(idx_q) * trt_pkg::DEG_HUNDREDTHS);
  assign frac_temp  = hit ? TEMP_W'(32'(k_nxt) * SubInc) : '0;

  always_comb begin
    sts_o          = '0;
    sts_o.in_range = (r_q > LastEntry) && (r_q < FirstEntry);
    sts_o.match    = (entry == r_q);
    sts_o.below    = (entry < r_q);
    sts_o.int_hit  = hit;
    sts_o.int_last = (k_nxt == KW'(SUB_STEPS));
    sts_o.out_free = !m_valid_q || m_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q   <= resistance_i;
      idx_q <= IW'(1);
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_q + IW'(1);
    end

    if (cmd_i.div_load) begin
      quot_q <= upper - entry;
      acc_q  <= upper;
      k_q    <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= prod[RecipShift +: RES_W];
    end else if (cmd_i.int_step) begin
      acc_q <= acc_nxt;
      k_q   <= k_nxt;
    end

    if (cmd_i.set_oor) begin
      res_temp_q <= '0;
      res_oor_q  <= 1'b1;
    end else if (cmd_i.set_exact) begin
      res_temp_q <= exact_temp;
      res_oor_q  <= 1'b0;
    end else if (cmd_i.set_interp) begin
      res_temp_q <= base_temp + frac_temp;
      res_oor_q  <= 1'b0;
    end

    if (cmd_i.push) begin
      m_temp_q <= res_temp_q;
      m_oor_q  <= res_oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_valid_o      = m_valid_q;
  assign temperature_o  = m_temp_q;
  assign out_of_range_o = m_oor_q;

endmodule

`default_nettype wire

FILE: hdl/thermistor_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_resistance_to_temperature
// Resistance code to temperature (0.01 degree) by table scan and interpolation.
// ----------------------------------------------------------------------------
// Sequence: an out-of-range word goes straight to finish; otherwise a scan to
// entry n ends at an exact hit, or, when the word lies between entries n-1
// and n, one multiply for the sub-step width and k <= SUB_STEPS sub-step
// checks follow. Finish waits out any output stall.
// Throughput: one word in flight; next word taken the cycle after the push.
// Reset: async active low, clears sequencer and output valid; no other state.
`default_nettype none

module thermistor_resistance_to_temperature #(
  parameter int unsigned TABLE_ENTRIES = trt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SUB_STEPS     = trt_pkg::SUB_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] resistance
  // result word
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [13:0] temperature, [15:14] zero
  output      logic [0:0]  m_axis_tuser    // [0] out_of_range
);

  trt_pkg::trt_cmd_t            cmd;
  trt_pkg::trt_sts_t            sts;
  logic [trt_pkg::TEMP_W-1:0]   temperature;
  logic                         out_of_range;

  // Sequencer: idle -> range check -> scan -> divide -> sub-steps -> finish.
  // Input is taken only in idle; a finished word waits in finish while the
  // output register is still occupied.
  trt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Datapath: scans the table one entry a cycle, divides the interval width
  // by SUB_STEPS with one reciprocal multiply, then walks the sub-steps down
  // from the upper entry.
  trt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SUB_STEPS     (SUB_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .resistance_i   (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .temperature_o  (temperature),
    .out_of_range_o (out_of_range)
  );

  assign m_axis_tdata = {{(16 - trt_pkg::TEMP_W){1'b0}}, temperature};
  assign m_axis_tuser = out_of_range;

  // Out-of-range words always carry zero temperature
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
    else $error("out_of_range word with nonzero temperature");

  // One word at a time: no second accept right after an accept
  a_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  // A push always presents a result next cycle
  a_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> m_axis_tvalid)
    else $error("push did not raise output valid");

  // Push only when the output register can take it
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("push over an untaken result");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the thermistor resistance to temperature converter.
// Drives resistance words over the input stream and predicts each result word
// from a private copy of the resistance table. A scoreboard checks the
// temperature and out-of-range fields in order. Directed edge cases come
// first, then random words under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_N      = 121;
  localparam int unsigned SUB_STEPS  = 10;
  localparam int unsigned HUNDREDTHS = 100;
  localparam int unsigned RAND_WORDS = 432;   // per idling phase
  localparam int unsigned IDLE_LIMIT = 4000;  // cycles without any handshake
  localparam int unsigned TAIL_WAIT  = 200;   // a bit over worst-case latency

  // Descending resistance codes, entry n is n whole degrees
  localparam int unsigned RES_TBL [TBL_N] = '{
    2208, 2201, 2194, 2187, 2180, 2172, 2163, 2155, 2146, 2137,
    2128, 2118, 2108, 2097, 2086, 2075, 2064, 2052, 2040, 2027,
    2014, 2001, 1987, 1973, 1958, 1944, 1928, 1913, 1897, 1880,
    1864, 1847, 1829, 1811, 1793, 1775, 1756, 1737, 1717, 1697,
    1677, 1657, 1636, 1615, 1594, 1572, 1551, 1529, 1507, 1484,
    1462, 1439, 1416, 1393, 1370, 1347, 1323, 1300, 1277, 1253,
    1229, 1206, 1182, 1159, 1135, 1111, 1088, 1064, 1041, 1018,
    995, 971, 949, 926, 903, 881, 858, 836, 814, 792,
    771, 750, 728, 708, 687, 667, 646, 626, 607, 587,
    568, 549, 531, 513, 494, 477, 459, 442, 425, 408,
    392, 376, 360, 344, 329, 314, 299, 285, 271, 257,
    243, 230, 216, 204, 191, 178, 166, 154, 143, 131,
    120
  };

  typedef struct packed {
    logic [trt_pkg::TEMP_W-1:0] temperature;
    logic                       out_of_range;
  } temp_word_t;

  // Expected result words in order, plus the mismatch count
  class temp_scoreboard;
    temp_word_t  expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Table scan with coarse sub-step interpolation
    function temp_word_t resistance_to_temp(logic [trt_pkg::RES_W-1:0] res);
      temp_word_t  w;
      int unsigned upper;
      int unsigned lower;
      int unsigned step_w;
      int unsigned frac;
      w.temperature  = '0;
      w.out_of_range = 1'b1;
      if (res > RES_TBL[TBL_N-1] && res < RES_TBL[0]) begin
        for (int unsigned n = 1; n < TBL_N; n++) begin
          if (res == RES_TBL[n]) begin
            w.temperature  = trt_pkg::TEMP_W'(n * HUNDREDTHS);
            w.out_of_range = 1'b0;
            break;
          end
          if (RES_TBL[n] < res) begin
            upper  = RES_TBL[n-1];
            lower  = RES_TBL[n];
            step_w = (upper - lower) / SUB_STEPS;
            frac   = 0;
            // no qualifying sub-step leaves frac at zero
            for (int unsigned k = 0; k <= SUB_STEPS; k++) begin
              if (upper - k * step_w < res) begin
                frac = k * (HUNDREDTHS / SUB_STEPS);
                break;
              end
            end
            w.temperature  = trt_pkg::TEMP_W'((n - 1) * HUNDREDTHS + frac);
            w.out_of_range = 1'b0;
            break;
          end
        end
      end
      return w;
    endfunction

    function void note_resistance(logic [trt_pkg::RES_W-1:0] res);
      expected_q.push_back(resistance_to_temp(res));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(logic [trt_pkg::TEMP_W-1:0] temp, logic oor);
      temp_word_t exp_w;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with none expected (temp %0d oor %0b)", temp, oor));
      end else begin
        exp_w = expected_q.pop_front();
        if (temp !== exp_w.temperature)
          report($sformatf("temperature %0d, expected %0d", temp, exp_w.temperature));
        if (oor !== exp_w.out_of_range)
          report($sformatf("out_of_range %0b, expected %0b", oor, exp_w.out_of_range));
      end
    endtask

    task drain_check();
      while (expected_q.size() != 0) begin
        void'(expected_q.pop_front());
        report("expected result word never arrived");
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic [15:0]                s_axis_tdata  = '0;
  logic                       s_axis_tready;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [15:0]                m_axis_tdata;
  logic [0:0]                 m_axis_tuser;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  temp_scoreboard sb = new();

  thermistor_resistance_to_temperature DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] resistance
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [13:0] temperature, [15:14] zero
    .m_axis_tuser (m_axis_tuser)    // [0] out_of_range
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Present one word, with random idle cycles ahead of it, until accepted
  task send_word(logic [15:0] res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_resistance(res);
  endtask

  // Random resistance, weighted toward the table range and its entries
  function logic [15:0] pick_resistance();
    int unsigned sel;
    int          val;
    sel = $urandom_range(99);
    if (sel < 55) begin
      val = $urandom_range(RES_TBL[0] - 1, RES_TBL[TBL_N-1] + 1);
    end else if (sel < 70) begin
      val = RES_TBL[$urandom_range(TBL_N - 1)];
    end else if (sel < 82) begin
      // just around an entry, edges included
      val = int'(RES_TBL[$urandom_range(TBL_N - 1)]) + int'($urandom_range(6)) - 3;
    end else if (sel < 92) begin
      val = $urandom_range(16'hFFFF);
    end else if (sel < 96) begin
      val = $urandom_range(RES_TBL[TBL_N-1]);
    end else begin
      val = $urandom_range(16'hFFFF, RES_TBL[0]);
    end
    return 16'(val);
  endfunction

  // Result side: random back-pressure, every accepted word goes to the check
  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata[trt_pkg::TEMP_W-1:0], m_axis_tuser[0]);
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] directed_q[$];
    directed_q = '{
      16'd0, 16'hFFFF, 16'hAAAA, 16'h5555,
      16'd2208, 16'd2209, 16'd2207,            // top edge
      16'd120, 16'd119, 16'd121, 16'd1,        // bottom edge
      16'd2201, 16'd1018, 16'd131, 16'd2172,   // exact entries
      16'd2205, 16'd2176,                      // step truncates to zero
      16'd2119, 16'd1205, 16'd1000, 16'd994,   // interpolated
      16'd1500, 16'd600, 16'd122
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_word(directed_q[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (RAND_WORDS) send_word(pick_resistance());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    sb.drain_check();

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
